@@ rtl/mhpq_pkg.sv @@
// ----------------------------------------------------------------------------
// mhpq_pkg
// Shared types, codes and defaults for the max-heap priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package mhpq_pkg;

  // Default number of heap entries
  localparam int CAPACITY_DEFAULT = 64;

  // Action codes carried by a request
  localparam logic [1:0] ACT_INSERT  = 2'd0;
  localparam logic [1:0] ACT_EXTRACT = 2'd1;
  localparam logic [1:0] ACT_PEEK    = 2'd2;

  // Status codes carried by a response
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  // Request payload
  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] item_value;
  } req_t;

  // Response payload
  typedef struct packed {
    logic signed [31:0] result_value;
    logic [1:0]         status;
  } resp_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_TOP_WAIT,
    ST_UP_RD,
    ST_UP_CMP,
    ST_DN_RD,
    ST_DN_CMP,
    ST_DONE
  } state_t;

  // Datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SET_FULL,
    OP_SET_EMPTY,
    OP_INS_INIT,
    OP_RD_TOP,
    OP_PEEK_TOP,
    OP_POP_TOP,
    OP_RD_PARENT,
    OP_UP_MOVE,
    OP_UP_PLACE,
    OP_RD_CHILD,
    OP_DN_MOVE,
    OP_DN_PLACE
  } dp_op_t;

  // Controller to datapath command
  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [1:0] action;
    logic       empty;
    logic       full;
    logic       last_one;
    logic       pos_zero;
    logic       parent_less;
    logic       child_better;
  } dp_status_t;

endpackage

`default_nettype wire

@@ rtl/mhpq_ram.sv @@
// ----------------------------------------------------------------------------
// mhpq_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mhpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr0,
  input  wire logic [$clog2(DEPTH)-1:0] raddr1,
  output logic      [WIDTH-1:0]         rdata0,
  output logic      [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered reads
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

`default_nettype wire

@@ rtl/mhpq_datapath.sv @@
// ----------------------------------------------------------------------------
// mhpq_datapath
// Heap store, entry count, sift position and moving key; executes one
// controller operation per cycle and reports compare results.
// ----------------------------------------------------------------------------
`default_nettype none

module mhpq_datapath #(
  parameter int CAPACITY = mhpq_pkg::CAPACITY_DEFAULT
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire mhpq_pkg::req_t       request,
  input  wire mhpq_pkg::dp_cmd_t    cmd,
  output mhpq_pkg::dp_status_t      dp_status,
  output mhpq_pkg::resp_t           response
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = AW + 2;

  logic [CW-1:0]       count;
  logic [AW-1:0]       pos;
  logic signed [31:0]  key;
  mhpq_pkg::req_t      item;
  mhpq_pkg::resp_t     res;

  logic                we;
  logic [AW-1:0]       waddr;
  logic [31:0]         wdata;
  logic [AW-1:0]       raddr0;
  logic [AW-1:0]       raddr1;
  logic [31:0]         rdata0;
  logic [31:0]         rdata1;

  logic signed [31:0]  rd0;
  logic signed [31:0]  rd1;
  logic [AW-1:0]       parent;
  logic [IW-1:0]       left;
  logic [IW-1:0]       right;
  logic                left_ok;
  logic                right_ok;
  logic                l_gt;
  logic                r_gt;
  logic signed [31:0]  l_best;

  mhpq_ram #(
    .WIDTH (32),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk    (clk),
    .we     (we),
    .waddr  (waddr),
    .wdata  (wdata),
    .raddr0 (raddr0),
    .raddr1 (raddr1),
    .rdata0 (rdata0),
    .rdata1 (rdata1)
  );

  // Tree neighbors of the current position
  always_comb begin
    rd0      = $signed(rdata0);
    rd1      = $signed(rdata1);
    parent   = AW'((pos - AW'(1)) >> 1);
    left     = {1'b0, pos, 1'b1};
    right    = left + IW'(1);
    left_ok  = left < IW'(count);
    right_ok = right < IW'(count);
    l_gt     = left_ok && (rd0 > key);
    l_best   = l_gt ? rd0 : key;
    r_gt     = right_ok && (rd1 > l_best);
  end

  // Status toward the controller
  always_comb begin
    dp_status.action       = item.action;
    dp_status.empty        = count == CW'(0);
    dp_status.full         = count == CW'(CAPACITY);
    dp_status.last_one     = count == CW'(1);
    dp_status.pos_zero     = pos == AW'(0);
    dp_status.parent_less  = rd0 < key;
    dp_status.child_better = l_gt || r_gt;
  end

  // Steer the memory ports by operation
  always_comb begin
    we     = 1'b0;
    waddr  = pos;
    wdata  = key;
    raddr0 = AW'(0);
    raddr1 = AW'(count - CW'(1));
    case (cmd.op)
      mhpq_pkg::OP_RD_PARENT: raddr0 = parent;
      mhpq_pkg::OP_RD_CHILD: begin
        raddr0 = left[AW-1:0];
        raddr1 = right[AW-1:0];
      end
      mhpq_pkg::OP_UP_MOVE: begin
        we    = 1'b1;
        wdata = rd0;
      end
      mhpq_pkg::OP_UP_PLACE: we = 1'b1;
      mhpq_pkg::OP_DN_MOVE: begin
        we    = 1'b1;
        wdata = r_gt ? rd1 : rd0;
      end
      mhpq_pkg::OP_DN_PLACE: we = 1'b1;
      default: we = 1'b0;
    endcase
  end

  // Hold the entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      case (cmd.op)
        mhpq_pkg::OP_UP_PLACE: count <= count + CW'(1);
        mhpq_pkg::OP_POP_TOP:  count <= count - CW'(1);
        default:               count <= count;
      endcase
    end
  end

  // Advance position, key, request and response registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      mhpq_pkg::OP_LOAD: begin
        item             <= request;
        res.result_value <= '0;
        res.status       <= mhpq_pkg::STAT_OK;
      end
      mhpq_pkg::OP_SET_FULL:  res.status <= mhpq_pkg::STAT_FULL;
      mhpq_pkg::OP_SET_EMPTY: res.status <= mhpq_pkg::STAT_EMPTY;
      mhpq_pkg::OP_INS_INIT: begin
        pos <= count[AW-1:0];
        key <= item.item_value;
      end
      mhpq_pkg::OP_PEEK_TOP: res.result_value <= rd0;
      mhpq_pkg::OP_POP_TOP: begin
        res.result_value <= rd0;
        key              <= rd1;
        pos              <= AW'(0);
      end
      mhpq_pkg::OP_UP_MOVE: pos <= parent;
      mhpq_pkg::OP_DN_MOVE: pos <= r_gt ? right[AW-1:0] : left[AW-1:0];
      default: pos <= pos;
    endcase
  end

  assign response = res;

endmodule

`default_nettype wire

@@ rtl/mhpq_ctrl.sv @@
// ----------------------------------------------------------------------------
// mhpq_ctrl
// Controller state machine: decodes the request and sequences the sift
// loops over the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module mhpq_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire mhpq_pkg::dp_status_t  dp_status,
  output mhpq_pkg::dp_cmd_t          cmd,
  output logic                       busy,
  output logic                       done
);

  mhpq_pkg::state_t state;
  mhpq_pkg::state_t state_next;

  // Hold the state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mhpq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      mhpq_pkg::ST_IDLE: begin
        if (start) state_next = mhpq_pkg::ST_DECODE;
      end
      mhpq_pkg::ST_DECODE: begin
        if (dp_status.action == mhpq_pkg::ACT_INSERT) begin
          state_next = dp_status.full ? mhpq_pkg::ST_DONE : mhpq_pkg::ST_UP_RD;
        end else if (dp_status.action == mhpq_pkg::ACT_EXTRACT ||
                     dp_status.action == mhpq_pkg::ACT_PEEK) begin
          state_next = dp_status.empty ? mhpq_pkg::ST_DONE : mhpq_pkg::ST_TOP_WAIT;
        end else begin
          state_next = mhpq_pkg::ST_DONE;
        end
      end
      mhpq_pkg::ST_TOP_WAIT: begin
        if (dp_status.action == mhpq_pkg::ACT_EXTRACT && !dp_status.last_one) begin
          state_next = mhpq_pkg::ST_DN_RD;
        end else begin
          state_next = mhpq_pkg::ST_DONE;
        end
      end
      mhpq_pkg::ST_UP_RD: begin
        state_next = dp_status.pos_zero ? mhpq_pkg::ST_DONE : mhpq_pkg::ST_UP_CMP;
      end
      mhpq_pkg::ST_UP_CMP: begin
        state_next = dp_status.parent_less ? mhpq_pkg::ST_UP_RD : mhpq_pkg::ST_DONE;
      end
      mhpq_pkg::ST_DN_RD:  state_next = mhpq_pkg::ST_DN_CMP;
      mhpq_pkg::ST_DN_CMP: begin
        state_next = dp_status.child_better ? mhpq_pkg::ST_DN_RD : mhpq_pkg::ST_DONE;
      end
      mhpq_pkg::ST_DONE: state_next = mhpq_pkg::ST_IDLE;
      default:           state_next = mhpq_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd.op = mhpq_pkg::OP_NONE;
    busy   = 1'b1;
    done   = 1'b0;
    case (state)
      mhpq_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) cmd.op = mhpq_pkg::OP_LOAD;
      end
      mhpq_pkg::ST_DECODE: begin
        if (dp_status.action == mhpq_pkg::ACT_INSERT) begin
          cmd.op = dp_status.full ? mhpq_pkg::OP_SET_FULL : mhpq_pkg::OP_INS_INIT;
        end else if (dp_status.action == mhpq_pkg::ACT_EXTRACT ||
                     dp_status.action == mhpq_pkg::ACT_PEEK) begin
          cmd.op = dp_status.empty ? mhpq_pkg::OP_SET_EMPTY : mhpq_pkg::OP_RD_TOP;
        end else begin
          cmd.op = mhpq_pkg::OP_NONE;
        end
      end
      mhpq_pkg::ST_TOP_WAIT: begin
        cmd.op = (dp_status.action == mhpq_pkg::ACT_EXTRACT) ?
                 mhpq_pkg::OP_POP_TOP : mhpq_pkg::OP_PEEK_TOP;
      end
      mhpq_pkg::ST_UP_RD: begin
        cmd.op = dp_status.pos_zero ? mhpq_pkg::OP_UP_PLACE : mhpq_pkg::OP_RD_PARENT;
      end
      mhpq_pkg::ST_UP_CMP: begin
        cmd.op = dp_status.parent_less ? mhpq_pkg::OP_UP_MOVE : mhpq_pkg::OP_UP_PLACE;
      end
      mhpq_pkg::ST_DN_RD:  cmd.op = mhpq_pkg::OP_RD_CHILD;
      mhpq_pkg::ST_DN_CMP: begin
        cmd.op = dp_status.child_better ? mhpq_pkg::OP_DN_MOVE : mhpq_pkg::OP_DN_PLACE;
      end
      mhpq_pkg::ST_DONE: done = 1'b1;
      default:           cmd.op = mhpq_pkg::OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/max_heap_priority_queue.sv @@
// Peek returns the root; insert places the value after the last entry and sifts it up
// while its parent is smaller; extract returns the root, moves the last entry to the root
// and sifts it down while a child is larger.
// Only one item is in work at a time, as each walks read, compare and write steps over the
// single heap RAM; a new start is taken only once the block is idle again.
// Results are shown for one cycle on done; the receiver cannot stall.
// Reset (rst, synchronous) empties the queue; RAM contents are not cleared.
// ----------------------------------------------------------------------------
// max_heap_priority_queue
// Binary max-heap priority queue of signed 32-bit values with insert,
// extract-max and peek-max commands.
// ----------------------------------------------------------------------------
`default_nettype none

module max_heap_priority_queue #(
  parameter int CAPACITY = mhpq_pkg::CAPACITY_DEFAULT
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire mhpq_pkg::req_t    request,
  output logic                   done,
  output mhpq_pkg::resp_t        response
);

  mhpq_pkg::dp_cmd_t    cmd;
  mhpq_pkg::dp_status_t dp_status;

  mhpq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .dp_status (dp_status),
    .cmd       (cmd),
    .busy      (busy),
    .done      (done)
  );

  mhpq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .request   (request),
    .cmd       (cmd),
    .dp_status (dp_status),
    .response  (response)
  );

endmodule

`default_nettype wire

@@ rtl/mhpq_checker.sv @@
// ----------------------------------------------------------------------------
// mhpq_checker
// Port-level checks on the command handshake and result strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module mhpq_checker (
  input wire logic            clk,
  input wire logic            rst,
  input wire logic            start,
  input wire logic            busy,
  input wire logic            done,
  input wire mhpq_pkg::resp_t response
);

  // A transfer makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after a transfer");

  // A result only appears while an item is in work
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("done without an item in work");

  // A result lasts one cycle and frees the block
  a_done_release: assert property (@(posedge clk) disable iff (rst)
    done |=> (!done && !busy))
    else $error("done not followed by idle");

  // Status codes are legal, and failed commands carry a zero value
  a_status_legal: assert property (@(posedge clk) disable iff (rst)
    done |-> (response.status == mhpq_pkg::STAT_OK ||
              ((response.status == mhpq_pkg::STAT_EMPTY ||
                response.status == mhpq_pkg::STAT_FULL) &&
               response.result_value == 32'sd0)))
    else $error("illegal response status");

endmodule

bind max_heap_priority_queue mhpq_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .start    (start),
  .busy     (busy),
  .done     (done),
  .response (response)
);

`default_nettype wire
